// ----- rtl/mafk_pkg.sv -----
// Package for the four-kind moving average block.
// Holds widths, register indexes, averaging kind codes and shared structs.
package mafk_pkg;

   localparam int DefaultMaxWindow = 1024;

   localparam int SampleWidth = 32;
   localparam int LengthWidth = 11;
   localparam int KindWidth   = 2;
   localparam int SumWidth    = 48;
   localparam int WsumWidth   = 56;
   localparam int DivWidth    = 64;

   localparam logic [KindWidth-1:0] KIND_EXP    = 2'd0;
   localparam logic [KindWidth-1:0] KIND_SIMPLE = 2'd1;
   localparam logic [KindWidth-1:0] KIND_WMA    = 2'd2;
   localparam logic [KindWidth-1:0] KIND_WILDER = 2'd3;

   localparam logic CSR_KIND   = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   typedef struct packed {
      logic                        start;
      logic signed [DivWidth-1:0]  dividend;
      logic        [DivWidth-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [DivWidth-1:0]  quotient;
   } div_rsp_type;

endpackage

// ----- rtl/moving_average_four_kinds_unit.sv -----
// Top level of the four-kind moving average block.
// Depends on mafk_pkg and mafk_divider.
//
// The block takes one signed Q16.16 sample per transaction and, once N samples
// of the current series have arrived, returns one moving average per sample:
// simple, exponential, weighted or Wilder, chosen by csr register 0; N is csr
// register 1 (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW). The last
// N samples live in a single-port synchronous window memory; sums and the last
// average live in registers. A sample that yields an average goes from
// acceptance to the result through one memory read of the oldest sample, sum
// updates and a multiply, and the shared bit-serial divider, which sets the
// rate. Samples that produce no result skip the divider. The next sample is
// accepted once the current one is done, even while a result still waits in
// the output register. Any csr write clears the series state.
module moving_average_four_kinds_unit
   import mafk_pkg::*;
#(
   parameter int MAX_WINDOW = DefaultMaxWindow
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SampleWidth-1:0] req_sample,
   input  logic                          req_new_series,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SampleWidth-1:0] rsp_average,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [LengthWidth-1:0]        csr_data
);

   localparam int AddrWidth = $clog2(MAX_WINDOW);
   localparam int NWidth    = $clog2(MAX_WINDOW + 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SUMS  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [KindWidth-1:0]        kind_ff;
   logic [LengthWidth-1:0]      length_ff;
   logic signed [SumWidth-1:0]  rsum_ff, rsum_in;
   logic signed [WsumWidth-1:0] wsum_ff, wsum_in;
   logic signed [SampleWidth-1:0] prev_ff, prev_in;
   logic [NWidth-1:0]           seen_ff, seen_in;
   logic [AddrWidth-1:0]        slot_ff, slot_in;
   logic signed [SampleWidth-1:0] x_ff;
   logic                        fill_ff;
   logic                        emit_ff;
   logic signed [DivWidth-1:0]  dividend_ff, dividend_in;
   logic [DivWidth-1:0]         divisor_ff, divisor_in;
   logic                        rsp_valid_ff;
   logic signed [SampleWidth-1:0] rsp_average_ff;

   logic [NWidth-1:0]           n_len;
   logic [AddrWidth-1:0]        cur_slot;
   logic                        csr_write;
   logic                        accept;
   logic [SampleWidth-1:0]      mem [MAX_WINDOW];
   logic signed [SampleWidth-1:0] oldest_ff;
   logic                        mem_we;
   div_req_type                 div_req;
   div_rsp_type                 div_rsp;
   logic signed [SampleWidth-1:0] new_avg;

   // Effective period, clamped into 1..MAX_WINDOW.
   always_comb begin
      if (length_ff == '0) begin
         n_len = NWidth'(1);
      end else if (32'(length_ff) > MAX_WINDOW) begin
         n_len = NWidth'(MAX_WINDOW);
      end else begin
         n_len = NWidth'(length_ff);
      end
   end

   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign accept    = req_valid && !req_stall;

   // A new series starts at slot zero with an empty window.
   assign cur_slot = (req_new_series || 32'(slot_ff) >= 32'(n_len)) ? '0 : slot_ff;

   // Window memory: read the oldest sample at acceptance, write in ST_SUMS.
   assign mem_we = (state_ff == ST_SUMS);
   always_ff @(posedge clock) begin
      if (accept) begin
         oldest_ff <= mem[cur_slot];
      end
      if (mem_we) begin
         mem[slot_ff] <= x_ff;
      end
   end

   assign div_req.start    = (state_ff == ST_DIV);
   assign div_req.dividend = dividend_ff;
   assign div_req.divisor  = divisor_ff;

   mafk_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign new_avg = SampleWidth'(div_rsp.quotient);

   always_comb begin
      state_in    = state_ff;
      rsum_in     = rsum_ff;
      wsum_in     = wsum_ff;
      prev_in     = prev_ff;
      seen_in     = seen_ff;
      slot_in     = slot_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               rsum_in = '0;
               wsum_in = '0;
               prev_in = '0;
               seen_in = '0;
               slot_in = '0;
            end else if (accept) begin
               slot_in = cur_slot;
               if (req_new_series) begin
                  rsum_in = '0;
                  wsum_in = '0;
                  prev_in = '0;
                  seen_in = '0;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SUMS;
         end
         ST_SUMS: begin
            // Update sums and advance the write slot.
            if (fill_ff) begin
               rsum_in = rsum_ff + SumWidth'(x_ff);
               seen_in = seen_ff + 1'b1;
               wsum_in = wsum_ff + WsumWidth'(x_ff) * $signed({1'b0, seen_in});
            end else begin
               wsum_in = wsum_ff + WsumWidth'(x_ff) * $signed({1'b0, n_len})
                         - WsumWidth'(rsum_ff);
               rsum_in = rsum_ff + SumWidth'(x_ff) - SumWidth'(oldest_ff);
            end
            slot_in = (32'(slot_ff) + 1 >= 32'(n_len)) ? '0 : slot_ff + 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!emit_ff && !(32'(seen_ff) >= 32'(n_len))) begin
               state_in = ST_IDLE;
            end else begin
               if (kind_ff == KIND_WMA) begin
                  dividend_in = DivWidth'(wsum_ff);
                  divisor_in  = DivWidth'((24'(n_len) * (24'(n_len) + 24'd1)) >> 1);
               end else if (!emit_ff || kind_ff == KIND_SIMPLE) begin
                  dividend_in = DivWidth'(rsum_ff);
                  divisor_in  = DivWidth'(n_len);
               end else if (kind_ff == KIND_EXP) begin
                  dividend_in = (DivWidth'(x_ff) - DivWidth'(prev_ff)) <<< 1;
                  divisor_in  = DivWidth'(n_len) + 1'b1;
               end else begin
                  dividend_in = DivWidth'(prev_ff * $signed({1'b0, n_len - 1'b1}))
                                + DivWidth'(x_ff);
                  divisor_in  = DivWidth'(n_len);
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (emit_ff && kind_ff == KIND_EXP && kind_ff != KIND_WMA) begin
                  prev_in = prev_ff + new_avg;
               end else begin
                  prev_in = new_avg;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_SIMPLE;
         length_ff    <= LengthWidth'(10);
         rsum_ff      <= '0;
         wsum_ff      <= '0;
         prev_ff      <= '0;
         seen_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsum_ff  <= rsum_in;
         wsum_ff  <= wsum_in;
         prev_ff  <= prev_in;
         seen_ff  <= seen_in;
         slot_ff  <= slot_in;
         if (csr_write) begin
            if (csr_index == CSR_KIND) begin
               kind_ff <= csr_data[KindWidth-1:0];
            end else begin
               length_ff <= csr_data;
            end
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         x_ff    <= req_sample;
         fill_ff <= req_new_series || (32'(seen_ff) < 32'(n_len));
         emit_ff <= !req_new_series && (32'(seen_ff) >= 32'(n_len));
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_average_ff <= prev_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

endmodule

// ----- rtl/mafk_divider.sv -----
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// Depends on mafk_pkg for widths and the request/response structs.
module mafk_divider
   import mafk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CntWidth = $clog2(DivWidth + 1);

   logic [DivWidth-1:0] rem_ff, rem_in;
   logic [DivWidth-1:0] quo_ff, quo_in;
   logic [DivWidth-1:0] dsr_ff, dsr_in;
   logic                neg_ff, neg_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivWidth:0]   trial;
   logic [DivWidth-1:0] rem_shift;

   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff[DivWidth-2:0], quo_ff[DivWidth-1]};
      trial     = {1'b0, rem_shift} - {1'b0, dsr_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend[DivWidth-1] ? (~div_req.dividend + 1'b1)
                                                : div_req.dividend;
         dsr_in  = div_req.divisor;
         neg_in  = div_req.dividend[DivWidth-1];
         cnt_in  = CntWidth'(DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial[DivWidth] ? rem_shift : trial[DivWidth-1:0];
         quo_in = {quo_ff[DivWidth-2:0], ~trial[DivWidth]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for moving_average_four_kinds_unit.
// Depends on mafk_pkg and the block's RTL; a scoreboard class predicts every average.
`timescale 1ns / 1ps

module tb;
   import mafk_pkg::*;

   localparam int WindowCap = 1024;
   localparam int SettleCycles = 100;
   localparam int WatchdogLimit = 3000;
   localparam int RandomItems = 1050;

   // Scoreboard: carries its own copy of the series state and the settings.
   // It works out the average that each accepted sample must produce.
   class average_scoreboard;
      logic [KindWidth-1:0] kind;
      int unsigned length_reg;
      longint window_mem[WindowCap];
      longint running_sum;
      longint weighted_sum;
      longint last_average;
      int unsigned seen;
      int unsigned slot_ptr;
      int expected_averages[$];
      int errors;

      function void clear_series();
         running_sum = 0;
         weighted_sum = 0;
         last_average = 0;
         seen = 0;
         slot_ptr = 0;
      endfunction

      function void reset_state();
         kind = KIND_SIMPLE;
         length_reg = 10;
         errors = 0;
         clear_series();
      endfunction

      function void write_register(logic index, logic [LengthWidth-1:0] data);
         if (index == CSR_KIND) kind = data[KindWidth-1:0];
         else length_reg = data;
         clear_series();
      endfunction

      // Notes an accepted sample and queues the average it must yield, if any.
      function void note_sample(logic signed [SampleWidth-1:0] sample, logic new_series);
         longint n;
         longint x;
         longint avg;
         longint oldest;
         int unsigned slot;
         n = (length_reg == 0) ? 1 : (length_reg > WindowCap ? WindowCap : length_reg);
         x = sample;
         if (new_series) clear_series();
         slot = (slot_ptr >= n) ? 0 : slot_ptr;
         if (seen < n) begin
            window_mem[slot] = x;
            running_sum += x;
            seen++;
            weighted_sum += longint'(seen) * x;
            slot_ptr = (slot + 1 >= n) ? 0 : slot + 1;
            if (seen < n) return;
            if (kind == KIND_WMA) avg = weighted_sum / ((n * (n + 1)) / 2);
            else avg = running_sum / n;
         end else begin
            oldest = window_mem[slot];
            weighted_sum = weighted_sum + n * x - running_sum;
            running_sum = running_sum + x - oldest;
            window_mem[slot] = x;
            slot_ptr = (slot + 1 >= n) ? 0 : slot + 1;
            case (kind)
               KIND_EXP: avg = last_average + (2 * (x - last_average)) / (n + 1);
               KIND_WMA: avg = weighted_sum / ((n * (n + 1)) / 2);
               KIND_WILDER: avg = (last_average * (n - 1) + x) / n;
               default: avg = running_sum / n;
            endcase
         end
         last_average = avg;
         expected_averages.push_back(int'(avg));
      endfunction

      // Compares one returned average with the oldest one still waiting.
      function void check_average(logic signed [SampleWidth-1:0] actual);
         int want;
         if (expected_averages.size() == 0) begin
            $display("%0t: unexpected average, expected none, actual %0d", $time, actual);
            errors++;
            return;
         end
         want = expected_averages.pop_front();
         if (want !== actual) begin
            $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, actual);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SampleWidth-1:0] req_sample;
   logic req_new_series;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [SampleWidth-1:0] rsp_average;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [LengthWidth-1:0] csr_data;

   average_scoreboard board;
   int idle_cycles;
   int stall_left;
   bit stall_quiet;
   bit gaps_quiet;
   int sent_items;

   moving_average_four_kinds_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .req_new_series(req_new_series),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_average(rsp_average),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Result side: checks every accepted average and then decides the next stall.
   // Outputs are read at the edge before the block's own updates land.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_average(rsp_average);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (stall_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left <= gap_length();
            rsp_stall <= 1'b0;
         end
      end
   end

   // The watchdog counts cycles in which no transaction moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("moving_average_four_kinds_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one sample, waits for its transaction, then leaves a random gap.
   // With no gap, valid simply stays high for the next sample.
   task automatic send_sample(logic signed [SampleWidth-1:0] sample, logic new_series);
      int gap;
      req_valid <= 1'b1;
      req_sample <= sample;
      req_new_series <= new_series;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(sample, new_series);
      sent_items++;
      gap = gaps_quiet ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender until every queued average has come back, then lets
   // the block settle, since a sample without a result may still be in work.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_averages.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [LengthWidth-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(logic [KindWidth-1:0] kind, logic [LengthWidth-1:0] length);
      write_csr(CSR_KIND, LengthWidth'(kind));
      write_csr(CSR_LENGTH, length);
   endtask

   // Samples: full-range noise, values near one level, or the extremes.
   function automatic logic signed [SampleWidth-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return $urandom;
      if (pick < 8) return 32'sh0064_0000 + $signed($urandom_range(0, 32'h0008_0000))
                          - 32'sh0004_0000;
      if (pick == 8) return 32'sh8000_0000;
      return 32'sh7fff_ffff;
   endfunction

   initial begin
      logic [KindWidth-1:0] kind;
      logic [LengthWidth-1:0] length;
      int phase_items;
      int pick;
      board = new();
      board.reset_state();
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_new_series = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_KIND;
      csr_data = '0;
      stall_quiet = 1'b0;
      gaps_quiet = 1'b0;
      sent_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings first: simple average over ten samples.
      repeat (11) send_sample(random_sample(), 1'b0);

      // Period one for every kind returns the sample itself; length zero acts as one.
      for (int k = 0; k < 4; k++) begin
         set_mode(k[KindWidth-1:0], (k == 0) ? 11'd0 : 11'd1);
         send_sample(32'sh8000_0000, 1'b0);
         send_sample(32'sh7fff_ffff, 1'b1);
      end

      // Short windows with the extremes, which stress the wide sums.
      for (int k = 0; k < 4; k++) begin
         set_mode(k[KindWidth-1:0], 11'd2);
         send_sample(32'sh7fff_ffff, 1'b0);
         send_sample(32'sh8000_0000, 1'b0);
         send_sample(32'sh7fff_ffff, 1'b0);
      end

      // Random phases, mostly small windows so that averages come often.
      while (sent_items < RandomItems) begin
         kind = KindWidth'($urandom_range(0, 3));
         pick = $urandom_range(0, 19);
         if (pick == 0) length = 11'd0;
         else if (pick < 15) length = LengthWidth'($urandom_range(1, 12));
         else length = LengthWidth'($urandom_range(13, 60));
         set_mode(kind, length);
         stall_quiet = ($urandom_range(0, 4) == 0);
         gaps_quiet = ($urandom_range(0, 4) == 0);
         phase_items = $urandom_range(10, 80);
         for (int i = 0; i < phase_items; i++)
            send_sample(random_sample(), ($urandom_range(0, 29) == 0));
      end

      drain();
      if (board.errors == 0) begin
         $display("moving_average_four_kinds_unit test passed");
      end else begin
         $display("moving_average_four_kinds_unit test failed");
      end
      $finish;
   end

endmodule
